// ----- rtl/spvd_pkg.sv -----
// Package for the swing peak/valley detector: phase codes, state and result types.
package spvd_pkg;

	localparam logic [2:0] PH_SKIP      = 3'd0;
	localparam logic [2:0] PH_DECIDE    = 3'd1;
	localparam logic [2:0] PH_RISE      = 3'd2;
	localparam logic [2:0] PH_RISE_TAIL = 3'd3;
	localparam logic [2:0] PH_FALL      = 3'd4;
	localparam logic [2:0] PH_FALL_TAIL = 3'd5;

	localparam logic [15:0] SKIP_COUNT_RESET = 16'd1000;

	localparam logic CFG_SKIP_COUNT      = 1'b0;
	localparam logic CFG_SWING_THRESHOLD = 1'b1;

	typedef struct packed {
		logic [2:0]         phase;
		logic [15:0]        skip_cnt;
		logic [31:0]        anchor_time;
		logic signed [15:0] anchor_value;
		logic [31:0]        ext_time;
		logic signed [15:0] ext_value;
		logic [31:0]        tail_time;
		logic signed [15:0] tail_value;
	} spvd_state_t;

	typedef struct packed {
		logic               is_peak;
		logic [31:0]        left_time;
		logic signed [15:0] left_value;
		logic [31:0]        cusp_time;
		logic signed [15:0] cusp_value;
		logic [31:0]        right_time;
		logic signed [15:0] right_value;
		logic [15:0]        swing;
	} spvd_result_t;

endpackage

// ----- rtl/spvd_step.sv -----
// Next-state and segment report logic for one sample of the swing detector.
module spvd_step
	import spvd_pkg::*;
(
	input  spvd_state_t        st,
	input  logic [31:0]        t,
	input  logic signed [15:0] v,
	input  logic               last,
	input  logic [15:0]        skip_count,
	input  logic [15:0]        swing_threshold,
	output spvd_state_t        st_next,
	output spvd_result_t       res,
	output logic               res_hit
);

	logic               peak;
	logic signed [15:0] lo;
	logic signed [15:0] hi;
	logic signed [16:0] diff;
	logic [15:0]        swing;
	logic               big_enough;
	spvd_state_t        anc;
	spvd_state_t        nxt;
	logic               finish;

	// Swing of the segment held in the state, as it stands before this sample.
	always_comb begin
		peak = st.anchor_value <= st.ext_value;
		lo   = (st.anchor_value < st.tail_value) ? st.anchor_value : st.tail_value;
		hi   = (st.anchor_value > st.tail_value) ? st.anchor_value : st.tail_value;
		if (peak) begin
			diff = {st.ext_value[15], st.ext_value} - {lo[15], lo};
		end else begin
			diff = {hi[15], hi} - {st.ext_value[15], st.ext_value};
		end
		swing      = diff[16] ? 16'd0 : diff[15:0];
		big_enough = swing >= swing_threshold;
	end

	always_comb begin
		res.is_peak     = peak;
		res.left_time   = st.anchor_time;
		res.left_value  = st.anchor_value;
		res.cusp_time   = st.ext_time;
		res.cusp_value  = st.ext_value;
		res.right_time  = st.tail_time;
		res.right_value = st.tail_value;
		res.swing       = swing;
	end

	always_comb begin
		anc              = st;
		anc.phase        = PH_DECIDE;
		anc.anchor_time  = t;
		anc.anchor_value = v;
		anc.ext_time     = t;
		anc.ext_value    = v;
		anc.tail_time    = t;
		anc.tail_value   = v;
	end

	always_comb begin
		nxt    = st;
		finish = 1'b0;
		unique case (st.phase)
			PH_DECIDE: begin
				if (v >= st.anchor_value) begin
					nxt.phase = PH_RISE;
					if (v > st.ext_value) begin
						nxt.ext_time  = t;
						nxt.ext_value = v;
					end
				end else begin
					nxt.phase = PH_FALL;
					if (v < st.ext_value) begin
						nxt.ext_time  = t;
						nxt.ext_value = v;
					end
				end
			end
			PH_RISE: begin
				if (v >= st.anchor_value) begin
					if (v > st.ext_value) begin
						nxt.ext_time  = t;
						nxt.ext_value = v;
					end
				end else begin
					nxt.tail_time  = t;
					nxt.tail_value = v;
					nxt.phase      = PH_RISE_TAIL;
				end
			end
			PH_RISE_TAIL: begin
				if (v < st.tail_value) begin
					nxt.tail_time  = t;
					nxt.tail_value = v;
				end else if (v > st.tail_value) begin
					finish = 1'b1;
					nxt    = anc;
				end
			end
			PH_FALL: begin
				if (v <= st.anchor_value) begin
					if (v < st.ext_value) begin
						nxt.ext_time  = t;
						nxt.ext_value = v;
					end
				end else begin
					nxt.tail_time  = t;
					nxt.tail_value = v;
					nxt.phase      = PH_FALL_TAIL;
				end
			end
			PH_FALL_TAIL: begin
				if (v > st.tail_value) begin
					nxt.tail_time  = t;
					nxt.tail_value = v;
				end else if (v < st.tail_value) begin
					finish = 1'b1;
					nxt    = anc;
				end
			end
			default: begin
				// Skipping leading samples; unused phase codes behave the same way.
				if (st.skip_cnt >= skip_count) begin
					nxt = anc;
				end else begin
					nxt.skip_cnt = st.skip_cnt + 16'd1;
				end
			end
		endcase
	end

	assign res_hit = finish && big_enough;
	assign st_next = last ? '0 : nxt;

endmodule

// ----- rtl/swing_peak_valley_detector.sv -----
// Top level of the swing peak/valley detector: input stage, state and result register.
//
//  channel  handshake                    payload
//  sample   sample_valid/sample_ready    sample_time, sample_value, last_sample
//  result   result_valid/result_ready    is_peak, left/cusp/right time and value, swing
//  config   cfg_we                       cfg_index, cfg_data
//
// One sample beat is taken every cycle while the input stage can move; a sample is registered
// in the input stage, then its state update and any report are made when it advances, and a
// result is offered from the result register. The result register is the only stall point:
// while it holds an untaken result the staged sample waits, and sample_ready stays high
// as long as that stage can move. Reset clears the detector state and both valid flags;
// configuration resets to a skip count of 1000 and a swing threshold of zero.
module swing_peak_valley_detector
	import spvd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  logic [31:0]        sample_time,
	input  logic signed [15:0] sample_value,
	input  logic               last_sample,
	output logic               result_valid,
	input  logic               result_ready,
	output logic               is_peak,
	output logic [31:0]        left_time,
	output logic signed [15:0] left_value,
	output logic [31:0]        cusp_time,
	output logic signed [15:0] cusp_value,
	output logic [31:0]        right_time,
	output logic signed [15:0] right_value,
	output logic [15:0]        swing
);

	logic [15:0]        skip_count_q;
	logic [15:0]        swing_threshold_q;
	logic               valid_s1;
	logic [31:0]        time_s1;
	logic signed [15:0] value_s1;
	logic               last_s1;
	spvd_state_t        state_q;
	spvd_state_t        state_next;
	spvd_result_t       res;
	logic               res_hit;
	spvd_result_t       res_q;
	logic               res_valid_q;
	logic               advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_count_q      <= SKIP_COUNT_RESET;
			swing_threshold_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SKIP_COUNT:      skip_count_q      <= cfg_data;
				CFG_SWING_THRESHOLD: swing_threshold_q <= cfg_data;
				default:             ;
			endcase
		end
	end

	// The staged sample is processed once the result register is free or being emptied.
	assign advance      = valid_s1 && (!res_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			time_s1  <= sample_time;
			value_s1 <= sample_value;
			last_s1  <= last_sample;
		end
	end

	spvd_step u_step (
		.st              (state_q),
		.t               (time_s1),
		.v               (value_s1),
		.last            (last_s1),
		.skip_count      (skip_count_q),
		.swing_threshold (swing_threshold_q),
		.st_next         (state_next),
		.res             (res),
		.res_hit         (res_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_next;
			end
			if (advance) begin
				res_valid_q <= res_hit;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_hit) begin
			res_q <= res;
		end
	end

	assign result_valid = res_valid_q;
	assign is_peak      = res_q.is_peak;
	assign left_time    = res_q.left_time;
	assign left_value   = res_q.left_value;
	assign cusp_time    = res_q.cusp_time;
	assign cusp_value   = res_q.cusp_value;
	assign right_time   = res_q.right_time;
	assign right_value  = res_q.right_value;
	assign swing        = res_q.swing;

endmodule

// ----- tb/tb_swing_peak_valley_detector.sv -----
// Self-checking testbench for the swing peak/valley detector, with a segment predictor.
class segment_ledger;
	logic [15:0]        skip_count;
	logic [15:0]        swing_threshold;
	logic [2:0]         phase;
	logic [15:0]        skip_cnt;
	logic [31:0]        anchor_time;
	logic signed [15:0] anchor_value;
	logic [31:0]        ext_time;
	logic signed [15:0] ext_value;
	logic [31:0]        tail_time;
	logic signed [15:0] tail_value;
	spvd_pkg::spvd_result_t due_segments[$];
	int errors;

	function new();
		skip_count = spvd_pkg::SKIP_COUNT_RESET;
		swing_threshold = '0;
		errors = 0;
		clear();
	endfunction

	function void clear();
		phase = spvd_pkg::PH_SKIP;
		skip_cnt = '0;
		anchor_time = '0;
		anchor_value = '0;
		ext_time = '0;
		ext_value = '0;
		tail_time = '0;
		tail_value = '0;
	endfunction

	function void set_register(logic idx, logic [15:0] data);
		if (idx == spvd_pkg::CFG_SKIP_COUNT) begin
			skip_count = data;
		end else begin
			swing_threshold = data;
		end
	endfunction

	function void set_anchor(logic [31:0] t, logic signed [15:0] v);
		anchor_time = t;
		anchor_value = v;
		ext_time = t;
		ext_value = v;
		tail_time = t;
		tail_value = v;
		phase = spvd_pkg::PH_DECIDE;
	endfunction

	// The segment closes against the anchor and the tail point; only a swing at or above
	// the threshold is reported.
	function void close_segment();
		spvd_pkg::spvd_result_t seg;
		logic peak;
		int bound;
		int sw;
		peak = (anchor_value <= ext_value);
		if (peak) begin
			bound = (anchor_value < tail_value) ? anchor_value : tail_value;
			sw = ext_value - bound;
		end else begin
			bound = (anchor_value > tail_value) ? anchor_value : tail_value;
			sw = bound - ext_value;
		end
		if (sw >= int'(swing_threshold)) begin
			seg = {peak, anchor_time, anchor_value, ext_time, ext_value,
				tail_time, tail_value, sw[15:0]};
			due_segments.push_back(seg);
		end
	endfunction

	function void take_sample(logic [31:0] t, logic signed [15:0] v, logic last);
		case (phase)
			spvd_pkg::PH_DECIDE: begin
				if (v >= anchor_value) begin
					phase = spvd_pkg::PH_RISE;
					if (v > ext_value) begin
						ext_time = t;
						ext_value = v;
					end
				end else begin
					phase = spvd_pkg::PH_FALL;
					if (v < ext_value) begin
						ext_time = t;
						ext_value = v;
					end
				end
			end
			spvd_pkg::PH_RISE: begin
				if (v >= anchor_value) begin
					if (v > ext_value) begin
						ext_time = t;
						ext_value = v;
					end
				end else begin
					tail_time = t;
					tail_value = v;
					phase = spvd_pkg::PH_RISE_TAIL;
				end
			end
			spvd_pkg::PH_RISE_TAIL: begin
				if (v < tail_value) begin
					tail_time = t;
					tail_value = v;
				end else if (v > tail_value) begin
					close_segment();
					set_anchor(t, v);
				end
			end
			spvd_pkg::PH_FALL: begin
				if (v <= anchor_value) begin
					if (v < ext_value) begin
						ext_time = t;
						ext_value = v;
					end
				end else begin
					tail_time = t;
					tail_value = v;
					phase = spvd_pkg::PH_FALL_TAIL;
				end
			end
			spvd_pkg::PH_FALL_TAIL: begin
				if (v > tail_value) begin
					tail_time = t;
					tail_value = v;
				end else if (v < tail_value) begin
					close_segment();
					set_anchor(t, v);
				end
			end
			default: begin
				if (skip_cnt >= skip_count) begin
					set_anchor(t, v);
				end else begin
					skip_cnt = skip_cnt + 16'd1;
				end
			end
		endcase
		if (last) begin
			clear();
		end
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0h, got %0h", name, want, seen);
			errors++;
		end
	endfunction

	function void check_segment(spvd_pkg::spvd_result_t got);
		spvd_pkg::spvd_result_t want;
		if (due_segments.size() == 0) begin
			$error("segment reported with none expected: %0h", got);
			errors++;
		end else begin
			want = due_segments.pop_front();
			compare_field("is_peak", want.is_peak, got.is_peak);
			compare_field("left_time", want.left_time, got.left_time);
			compare_field("left_value", want.left_value, got.left_value);
			compare_field("cusp_time", want.cusp_time, got.cusp_time);
			compare_field("cusp_value", want.cusp_value, got.cusp_value);
			compare_field("right_time", want.right_time, got.right_time);
			compare_field("right_value", want.right_value, got.right_value);
			compare_field("swing", want.swing, got.swing);
		end
	endfunction
endclass

module tb_swing_peak_valley_detector;
	import spvd_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_PHASES = 5;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_index = CFG_SKIP_COUNT;
	logic [15:0]        cfg_data = '0;
	logic               sample_valid = 1'b0;
	logic               sample_ready;
	logic [31:0]        sample_time = '0;
	logic signed [15:0] sample_value = '0;
	logic               last_sample = 1'b0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic               is_peak;
	logic [31:0]        left_time;
	logic signed [15:0] left_value;
	logic [31:0]        cusp_time;
	logic signed [15:0] cusp_value;
	logic [31:0]        right_time;
	logic signed [15:0] right_value;
	logic [15:0]        swing;

	segment_ledger ledger = new();

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_off_len = 0;
	int quiet_cycles = 0;

	// State of the random walk that shapes the sample stream.
	logic [31:0] walk_time = '0;
	int walk_value = 0;
	int walk_dir = 1;
	int run_left = 0;
	int step_scale = 2;

	swing_peak_valley_detector u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_time(sample_time),
		.sample_value(sample_value),
		.last_sample(last_sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.is_peak(is_peak),
		.left_time(left_time),
		.left_value(left_value),
		.cusp_time(cusp_time),
		.cusp_value(cusp_value),
		.right_time(right_time),
		.right_value(right_value),
		.swing(swing)
	);

	always #5 clk = ~clk;

	// Beats are observed at the edge with the values from before it.
	always @(posedge clk) begin
		spvd_result_t got;
		if (sample_valid && sample_ready) begin
			ledger.take_sample(sample_time, sample_value, last_sample);
		end
		if (result_valid && result_ready) begin
			got = {is_peak, left_time, left_value, cusp_time, cusp_value,
				right_time, right_value, swing};
			ledger.check_segment(got);
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
		end
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// The receiver counts a requested hold-off down itself, otherwise it stalls at random.
	always @(posedge clk) begin
		if (hold_off_len > 0) begin
			result_ready <= 1'b0;
			hold_off_len = hold_off_len - 1;
		end else begin
			result_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	task automatic send_sample(input logic [31:0] t, input logic signed [15:0] v,
			input logic last);
		int gap;
		sample_valid <= 1'b1;
		sample_time <= t;
		sample_value <= v;
		last_sample <= last;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct) gap++;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic pick_sample(output logic [31:0] t, output logic signed [15:0] v,
			output logic last);
		if ($urandom_range(99) < 4) begin
			walk_time = $urandom();
		end else begin
			walk_time = walk_time + $urandom_range(1, 1000);
		end
		t = walk_time;
		if ($urandom_range(99) < 8) begin
			walk_value = int'($urandom_range(65535)) - 32768;
		end else begin
			if (run_left == 0) begin
				walk_dir = -walk_dir;
				run_left = $urandom_range(1, 6);
				case ($urandom_range(3))
					0: step_scale = 2;
					1: step_scale = 50;
					2: step_scale = 3000;
					default: step_scale = 40000;
				endcase
			end
			walk_value = walk_value + walk_dir * int'($urandom_range(step_scale));
			if (walk_value > 32767) walk_value = 32767;
			if (walk_value < -32768) walk_value = -32768;
			run_left--;
		end
		v = walk_value[15:0];
		last = ($urandom_range(63) == 0);
	endtask

	task automatic send_random(input int count);
		logic [31:0] t;
		logic signed [15:0] v;
		logic last;
		for (int i = 0; i < count; i++) begin
			pick_sample(t, v, last);
			send_sample(t, v, last);
		end
	endtask

	// Stop offering, let every expected segment arrive and the pipeline empty.
	task automatic settle();
		sample_valid <= 1'b0;
		while (ledger.due_segments.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		ledger.set_register(idx, data);
		@(posedge clk);
	endtask

	initial begin
		logic [15:0] skip_set [RANDOM_PHASES] = '{16'd0, 16'd3, 16'd0, 16'd17, 16'd1};
		logic [15:0] thr_set [RANDOM_PHASES] = '{16'd0, 16'd100, 16'd1000, 16'd0, 16'd30000};
		int send_set [RANDOM_PHASES] = '{0, 56, 0, 7, 0};
		int recv_set [RANDOM_PHASES] = '{0, 0, 56, 7, 0};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset skip count every sample is dropped.
		send_random(30);
		settle();
		write_reg(CFG_SKIP_COUNT, 16'hFFFF);
		write_reg(CFG_SWING_THRESHOLD, 16'hFFFF);
		send_random(10);
		settle();
		// Lowering the skip count mid-series ends skipping at the next sample.
		write_reg(CFG_SKIP_COUNT, 16'd0);

		// Full-scale peak and valley that just meet the largest threshold; ties never
		// replace a kept extreme.
		send_sample(32'd0, 16'sh8001, 1'b0);
		send_sample(32'd1, 16'sh7FFF, 1'b0);
		send_sample(32'd2, 16'sh7FFF, 1'b0);
		send_sample(32'd3, 16'sh8000, 1'b0);
		send_sample(32'd4, 16'sh8000, 1'b0);
		send_sample(32'd5, 16'sh7FFE, 1'b0);
		send_sample(32'd6, 16'sh8000, 1'b0);
		send_sample(32'd7, 16'sh8000, 1'b0);
		send_sample(32'd8, 16'sh7FFF, 1'b0);
		send_sample(32'd9, 16'sh7FFF, 1'b0);
		send_sample(32'd10, 16'sh0000, 1'b0);
		send_sample(32'd11, 16'sd100, 1'b0);
		// A small swing is dropped, and the last sample clears the detector.
		send_sample(32'hFFFF_FFFF, 16'sd100, 1'b0);
		send_sample(32'd12, -16'sd50, 1'b0);
		send_sample(32'd13, 16'sd60, 1'b1);
		settle();
		write_reg(CFG_SWING_THRESHOLD, 16'd0);

		// A segment finished by the last sample is still reported.
		send_sample(32'h8000_0000, 16'sd5, 1'b0);
		send_sample(32'h8000_0001, 16'sd3, 1'b0);
		send_sample(32'h8000_0002, 16'sd4, 1'b0);
		send_sample(32'h8000_0003, 16'sd6, 1'b0);
		send_sample(32'h8000_0004, 16'sd5, 1'b1);
		// An unfinished segment is dropped at the last sample.
		send_sample(32'h0000_FFFF, 16'sd7, 1'b0);
		send_sample(32'h0001_0000, 16'sd9, 1'b0);
		send_sample(32'h0001_0001, 16'sd2, 1'b1);
		send_sample(32'h0001_0002, -16'sd1, 1'b0);
		send_sample(32'h0001_0003, -16'sd1, 1'b0);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_reg(CFG_SKIP_COUNT, skip_set[p]);
			write_reg(CFG_SWING_THRESHOLD, thr_set[p]);
			sender_idle_pct = send_set[p];
			receiver_stall_pct = recv_set[p];
			if (p == 0) begin
				send_random(150);
				// Long receiver hold-off while the sender keeps offering beats.
				hold_off_len = 400;
				send_random(100);
				settle();
				send_random(90);
			end else begin
				send_random(340);
			end
			settle();
		end

		if (ledger.errors == 0 && ledger.due_segments.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
